### sv/wpb_pkg.sv
package wpb_pkg;

   // field widths
   localparam int COORD_W  = 13;
   localparam int DIM_W    = 13;
   localparam int MASK_W   = 3;
   localparam int COLOR_W  = 8;
   localparam int WEIGHT_W = 24;

   // datapath widths
   localparam int CHAN_W   = 36;
   localparam int WSUM_W   = 29;
   localparam int PROD_W   = WEIGHT_W + COLOR_W;
   localparam int NUM_W    = CHAN_W + 2;
   localparam int QUO_W    = COLOR_W + 1;
   localparam int STEP_W   = 4;
   localparam int CHAN_N   = 3;
   localparam int CHAN_IDX_W = 2;
   localparam int POS_W    = COORD_W + 2;

   // mask bit positions
   localparam int MASK_HERE  = 0;
   localparam int MASK_BELOW = 1;
   localparam int MASK_RIGHT = 2;

   localparam logic [COLOR_W-1:0] SEAM_RED    = 8'd255;
   localparam logic [COLOR_W-1:0] ALPHA_SOLID = 8'd255;
   localparam logic [COLOR_W-1:0] ALPHA_HALF  = 8'd127;
   localparam logic [COLOR_W-1:0] COLOR_SAT   = 8'd255;

   localparam logic [STEP_W-1:0]     MAC_LAST  = 4'd3;
   localparam logic [STEP_W-1:0]     DIV_LAST  = 4'd8;
   localparam logic [CHAN_IDX_W-1:0] CHAN_LAST = 2'd2;

   typedef logic [COLOR_W-1:0]  color_type;
   typedef logic [CHAN_W-1:0]   chan_sum_type;
   typedef logic [WSUM_W-1:0]   wsum_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_EMIT
   } state_type;

endpackage

### sv/wpb_chan_if.sv
interface wpb_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wpb_pkg::COORD_W-1:0]  local_x;
   logic signed [wpb_pkg::COORD_W-1:0]  local_y;
   logic        [wpb_pkg::DIM_W-1:0]    src_width;
   logic        [wpb_pkg::DIM_W-1:0]    src_height;
   logic        [wpb_pkg::MASK_W-1:0]   mask_bits;
   logic        [wpb_pkg::COLOR_W-1:0]  blue_in;
   logic        [wpb_pkg::COLOR_W-1:0]  green_in;
   logic        [wpb_pkg::COLOR_W-1:0]  red_in;
   logic        [wpb_pkg::COLOR_W-1:0]  alpha_in;
   logic        [wpb_pkg::WEIGHT_W-1:0] weight;
   logic                                last_source;

   modport source (
      output valid, local_x, local_y, src_width, src_height, mask_bits,
             blue_in, green_in, red_in, alpha_in, weight, last_source,
      input  ready
   );
   modport sink (
      input  valid, local_x, local_y, src_width, src_height, mask_bits,
             blue_in, green_in, red_in, alpha_in, weight, last_source,
      output ready
   );
endinterface

interface wpb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic       [wpb_pkg::COLOR_W-1:0]  blue_out;
   logic       [wpb_pkg::COLOR_W-1:0]  green_out;
   logic       [wpb_pkg::COLOR_W-1:0]  red_out;
   logic       [wpb_pkg::COLOR_W-1:0]  alpha_out;

   modport source (
      output valid, blue_out, green_out, red_out, alpha_out,
      input  ready
   );
   modport sink (
      input  valid, blue_out, green_out, red_out, alpha_out,
      output ready
   );
endinterface

### sv/weighted_pixel_blender_with_seam.sv
// Weighted pixel blender with seam marking.
// req_chan carries one request per source image contributing to an output
// pixel; last_source closes the run. rsp_chan carries one blended BGRA pixel
// per run. csr_wr_en/csr_wr_data set ignore_weights (write only while idle).
// Operation: the block takes one request at a time. A request that is not last
// occupies it for the accept step plus four multiply/accumulate steps on one
// shared 24x8 multiplier. A last request with a nonzero weight sum adds three
// divisions on one shared 38-bit compare/subtract unit, each a load step, the
// shift/subtract steps and a store step, before its pixel is emitted; with a zero
// weight sum the zero pixel goes to the emit step straight after accumulation.
// The result sits in an output register: the next run may proceed while it
// waits, and only a second finished pixel waits for the receiver to take the
// first (the block then stalls in its emit step with req_chan.ready low).
// Reset (synchronous, active high) clears the sums, ignore_weights, the state
// machine and the output valid flag.
module weighted_pixel_blender_with_seam #(
   parameter int EDGE_MARGIN = 10
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   wpb_req_if.sink   req_chan,
   wpb_rsp_if.source rsp_chan
);

   localparam logic signed [wpb_pkg::POS_W-1:0] MARGIN = wpb_pkg::POS_W'(EDGE_MARGIN);

   wpb_pkg::state_type state_ff, state_in;

   logic                              ignore_ff, ignore_in;
   wpb_pkg::chan_sum_type             acc_ff [wpb_pkg::CHAN_N];
   wpb_pkg::chan_sum_type             acc_in [wpb_pkg::CHAN_N];
   wpb_pkg::wsum_type                 wacc_ff, wacc_in;
   wpb_pkg::weight_type               weff_ff, weff_in;
   wpb_pkg::color_type                col_ff [wpb_pkg::CHAN_N];
   wpb_pkg::color_type                col_in [wpb_pkg::CHAN_N];
   logic                              last_ff, last_in;
   logic [wpb_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [wpb_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [wpb_pkg::CHAN_IDX_W-1:0]    ch_ff, ch_in;
   logic [wpb_pkg::NUM_W-1:0]         rem_ff, rem_in;
   logic [wpb_pkg::NUM_W-1:0]         dvs_ff, dvs_in;
   logic [wpb_pkg::QUO_W-1:0]         quo_ff, quo_in;
   wpb_pkg::color_type                res_ff [wpb_pkg::CHAN_N];
   wpb_pkg::color_type                res_in [wpb_pkg::CHAN_N];

   logic                              rsp_valid_ff, rsp_valid_in;
   wpb_pkg::color_type                out_b_ff, out_b_in;
   wpb_pkg::color_type                out_g_ff, out_g_in;
   wpb_pkg::color_type                out_r_ff, out_r_in;
   wpb_pkg::color_type                out_a_ff, out_a_in;

   logic accept;
   logic load;
   logic covered;
   logic seam;
   logic contrib;
   logic ge;
   wpb_pkg::weight_type weff;
   logic signed [wpb_pkg::POS_W-1:0] lx_s, ly_s, w_s, h_s;

   assign accept = req_chan.valid && req_chan.ready;
   assign load   = (state_ff == wpb_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // Position tests on the incoming request, evaluated in the accept cycle.
   always_comb begin
      lx_s = {{2{req_chan.local_x[wpb_pkg::COORD_W-1]}}, req_chan.local_x};
      ly_s = {{2{req_chan.local_y[wpb_pkg::COORD_W-1]}}, req_chan.local_y};
      w_s  = {2'b00, req_chan.src_width};
      h_s  = {2'b00, req_chan.src_height};
      covered = (lx_s >= 15'sd0) && (lx_s < w_s) && (ly_s >= 15'sd0) && (ly_s < h_s);
      // a seam sits where the mask is set here and ends below or to the right,
      // away from the far edges
      seam = covered && req_chan.mask_bits[wpb_pkg::MASK_HERE]
             && (lx_s < w_s - MARGIN) && (ly_s < h_s - MARGIN)
             && !(req_chan.mask_bits[wpb_pkg::MASK_BELOW]
                  && req_chan.mask_bits[wpb_pkg::MASK_RIGHT]);
      contrib = covered && req_chan.mask_bits[wpb_pkg::MASK_HERE]
                && (!ignore_ff || (req_chan.alpha_in > wpb_pkg::ALPHA_HALF));
      // fold every "adds nothing" case into a zero weight
      if (!contrib) begin
         weff = '0;
      end else if (ignore_ff) begin
         weff = wpb_pkg::WEIGHT_W'(1);
      end else begin
         weff = req_chan.weight;
      end
   end

   assign ge = rem_ff >= dvs_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpb_pkg::ST_IDLE: begin
            if (accept) state_in = wpb_pkg::ST_MAC;
         end
         wpb_pkg::ST_MAC: begin
            if (step_ff == wpb_pkg::MAC_LAST) begin
               if (!last_ff) begin
                  state_in = wpb_pkg::ST_IDLE;
               end else if (wacc_ff == '0) begin
                  state_in = wpb_pkg::ST_EMIT;
               end else begin
                  state_in = wpb_pkg::ST_DIV_LOAD;
               end
            end
         end
         wpb_pkg::ST_DIV_LOAD: begin
            state_in = wpb_pkg::ST_DIV_STEP;
         end
         wpb_pkg::ST_DIV_STEP: begin
            if (step_ff == wpb_pkg::DIV_LAST) state_in = wpb_pkg::ST_DIV_STORE;
         end
         wpb_pkg::ST_DIV_STORE: begin
            if (ch_ff == wpb_pkg::CHAN_LAST) begin
               state_in = wpb_pkg::ST_EMIT;
            end else begin
               state_in = wpb_pkg::ST_DIV_LOAD;
            end
         end
         wpb_pkg::ST_EMIT: begin
            if (load) state_in = wpb_pkg::ST_IDLE;
         end
         default: state_in = wpb_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_chan.ready     = (state_ff == wpb_pkg::ST_IDLE);
      rsp_chan.valid     = rsp_valid_ff;
      rsp_chan.blue_out  = out_b_ff;
      rsp_chan.green_out = out_g_ff;
      rsp_chan.red_out   = out_r_ff;
      rsp_chan.alpha_out = out_a_ff;
   end

   // Datapath. Channel words rotate through place 0, so the shared multiplier
   // and the shared divider only ever look at one fixed slot.
   always_comb begin
      ignore_in = csr_wr_en ? csr_wr_data : ignore_ff;
      acc_in    = acc_ff;
      wacc_in   = wacc_ff;
      weff_in   = weff_ff;
      col_in    = col_ff;
      last_in   = last_ff;
      prod_in   = prod_ff;
      step_in   = step_ff;
      ch_in     = ch_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      res_in    = res_ff;

      case (state_ff)
         wpb_pkg::ST_IDLE: begin
            if (accept) begin
               weff_in   = weff;
               col_in[0] = req_chan.blue_in;
               col_in[1] = req_chan.green_in;
               col_in[2] = req_chan.red_in;
               last_in   = req_chan.last_source;
               step_in   = '0;
               // seam: restart the sums as pure red at weight one
               if (seam) begin
                  acc_in[0] = '0;
                  acc_in[1] = '0;
                  acc_in[2] = wpb_pkg::CHAN_W'(wpb_pkg::SEAM_RED);
               end
               wacc_in = (seam ? wpb_pkg::WSUM_W'(1) : wacc_ff) + wpb_pkg::WSUM_W'(weff);
            end
         end
         wpb_pkg::ST_MAC: begin
            // multiply one channel while adding the previous product
            if (step_ff != wpb_pkg::MAC_LAST) begin
               prod_in   = wpb_pkg::PROD_W'(weff_ff) * wpb_pkg::PROD_W'(col_ff[0]);
               col_in[0] = col_ff[1];
               col_in[1] = col_ff[2];
               col_in[2] = col_ff[0];
            end
            if (step_ff != '0) begin
               acc_in[0] = acc_ff[1];
               acc_in[1] = acc_ff[2];
               acc_in[2] = acc_ff[0] + wpb_pkg::CHAN_W'(prod_ff);
            end
            step_in = step_ff + wpb_pkg::STEP_W'(1);
            if (step_ff == wpb_pkg::MAC_LAST) begin
               ch_in = '0;
               if (wacc_ff == '0) begin
                  res_in[0] = '0;
                  res_in[1] = '0;
                  res_in[2] = '0;
               end
            end
         end
         wpb_pkg::ST_DIV_LOAD: begin
            // round half up: (2*sum + w) / (2*w)
            rem_in    = wpb_pkg::NUM_W'({acc_ff[0], 1'b0}) + wpb_pkg::NUM_W'(wacc_ff);
            dvs_in    = {wacc_ff, {wpb_pkg::QUO_W{1'b0}}};
            quo_in    = '0;
            step_in   = '0;
            acc_in[0] = acc_ff[1];
            acc_in[1] = acc_ff[2];
            acc_in[2] = acc_ff[0];
         end
         wpb_pkg::ST_DIV_STEP: begin
            rem_in  = ge ? rem_ff - dvs_ff : rem_ff;
            quo_in  = {quo_ff[wpb_pkg::QUO_W-2:0], ge};
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + wpb_pkg::STEP_W'(1);
         end
         wpb_pkg::ST_DIV_STORE: begin
            // saturate when the quotient reaches bit eight
            res_in[0] = res_ff[1];
            res_in[1] = res_ff[2];
            res_in[2] = quo_ff[wpb_pkg::QUO_W-1] ? wpb_pkg::COLOR_SAT
                                                 : quo_ff[wpb_pkg::COLOR_W-1:0];
            ch_in     = ch_ff + wpb_pkg::CHAN_IDX_W'(1);
         end
         wpb_pkg::ST_EMIT: begin
            if (load) begin
               acc_in[0] = '0;
               acc_in[1] = '0;
               acc_in[2] = '0;
               wacc_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load a finished pixel, drop it once taken.
   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
      out_b_in     = out_b_ff;
      out_g_in     = out_g_ff;
      out_r_in     = out_r_ff;
      out_a_in     = out_a_ff;
      if (load) begin
         out_b_in = res_ff[0];
         out_g_in = res_ff[1];
         out_r_in = res_ff[2];
         out_a_in = (wacc_ff != '0) ? wpb_pkg::ALPHA_SOLID : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpb_pkg::ST_IDLE;
         ignore_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
         wacc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ignore_ff    <= ignore_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         wacc_ff      <= wacc_in;
      end
   end

   always_ff @(posedge clock) begin
      weff_ff  <= weff_in;
      col_ff   <= col_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      ch_ff    <= ch_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      res_ff   <= res_in;
      out_b_ff <= out_b_in;
      out_g_ff <= out_g_in;
      out_r_ff <= out_r_in;
      out_a_ff <= out_a_in;
   end

`ifndef NO_ASSERTIONS
   // the divider only runs on a nonzero weight sum
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpb_pkg::ST_DIV_STEP) |-> (wacc_ff != '0))
      else $error("divider running on a zero weight sum");

   // an accepted request starts the multiply/accumulate sequence at step zero
   a_accept_mac: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == wpb_pkg::ST_MAC) && (step_ff == '0))
      else $error("accepted request did not enter accumulation");

   // emitting a pixel presents it and clears the sums
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff && (wacc_ff == '0) && (acc_ff[0] == '0))
      else $error("emitted pixel left sums uncleared or not presented");
`endif

endmodule
